### sv/lscp_pkg.sv
// ----------------------------------------------------------------------------
// lscp_pkg
// Shared types and constants for the slot cache policy block: request and
// response beats, the stored entry layout and the scan tracker status.
// ----------------------------------------------------------------------------
package lscp_pkg;

    localparam int NUM_SLOTS_DEF = 256;
    localparam int SLOT_IDX_W    = 12;

    localparam logic REQ_USE  = 1'b0;
    localparam logic REQ_FREE = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [31:0]        sound_key;
        logic signed [31:0] now_ticks;
    } req_t;

    typedef struct packed {
        logic [7:0]  slot_index;
        logic        hit;
        logic        evicted;
        logic [31:0] evicted_key;
        logic        action_taken;
    } rsp_t;

    typedef struct packed {
        logic               active;
        logic [31:0]        key;
        logic signed [31:0] stamp;
    } ent_t;

    typedef struct packed {
        logic                  have_match;
        logic [SLOT_IDX_W-1:0] match_idx;
        logic                  have_free;
        logic [SLOT_IDX_W-1:0] free_idx;
        logic                  have_oldest;
        logic [SLOT_IDX_W-1:0] oldest_idx;
        logic signed [31:0]    oldest_time;
        logic [31:0]           oldest_key;
        logic [31:0]           key0;
    } track_t;

endpackage

### sv/lscp_ram.sv
// ----------------------------------------------------------------------------
// lscp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lscp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/lscp_track.sv
// ----------------------------------------------------------------------------
// lscp_track
// Scan tracker: watches entries streaming out of the entry memory and keeps
// the first key match, first free slot, strictly oldest stamp and slot 0 key.
// ----------------------------------------------------------------------------
module lscp_track
    import lscp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [31:0]    now_ticks,
    input  logic [31:0]           sound_key,
    input  logic                  rd_valid,
    input  logic [SLOT_IDX_W-1:0] rd_idx,
    input  ent_t                  rd_ent,
    output track_t                trk
);

    track_t trk_reg;
    track_t trk_next;

    always_comb
    begin
        trk_next = trk_reg;
        if (start)
        begin
            trk_next.have_match  = 1'b0;
            trk_next.have_free   = 1'b0;
            trk_next.have_oldest = 1'b0;
            trk_next.oldest_time = now_ticks;
        end
        else if (rd_valid)
        begin
            if (!trk_reg.have_match && rd_ent.active && (rd_ent.key == sound_key))
            begin
                trk_next.have_match = 1'b1;
                trk_next.match_idx  = rd_idx;
            end
            if (!trk_reg.have_free && !rd_ent.active)
            begin
                trk_next.have_free = 1'b1;
                trk_next.free_idx  = rd_idx;
            end
            if (rd_ent.stamp < trk_reg.oldest_time)
            begin
                trk_next.have_oldest = 1'b1;
                trk_next.oldest_idx  = rd_idx;
                trk_next.oldest_time = rd_ent.stamp;
                trk_next.oldest_key  = rd_ent.key;
            end
            if (rd_idx == '0)
            begin
                trk_next.key0 = rd_ent.key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_reg <= '0;
        end
        else
        begin
            trk_reg <= trk_next;
        end
    end

    assign trk = trk_reg;

endmodule

### sv/lru_slot_cache_policy.sv
// ----------------------------------------------------------------------------
// lru_slot_cache_policy
// Fully associative slot cache with timestamp replacement. Entries live in
// one memory; an enabled request scans all slots and writes at most one entry.
//
//   channel   dir   handshake               beat
//   req       in    req_valid / req_ready   req_t  (type, key, now)
//   rsp       out   rsp_valid / rsp_ready   rsp_t  (slot, hit, evict, key, act)
//   cfg       in    cfg_wr_en               cfg_wr_data (audio enable)
//
// An enabled request scans the entry memory through its single read port,
// one entry per cycle, before its result is formed. A disabled request
// skips the scan.
// After reset a clearing pass writes zero to all NUM_SLOTS entries, one per
// cycle; no request is accepted until it ends.
// A result waiting in the output register does not block the next accept;
// the write-back holds until the output register is free.
// ----------------------------------------------------------------------------
module lru_slot_cache_policy
    import lscp_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    req_t          item_reg, item_next;
    logic          item_en_reg, item_en_next;
    logic          enable_reg, enable_next;
    rsp_t          rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic                  accept;
    logic                  out_free;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    ent_t                  mem_wdata;
    logic                  mem_re;
    logic [$bits(ent_t)-1:0] mem_rdata;
    track_t                trk;

    logic                  wr_want;
    logic [IW-1:0]         wr_idx;
    ent_t                  wr_ent;
    rsp_t                  rsp_calc;
    logic [IW-1:0]         victim_idx;
    logic [31:0]           victim_key;
    logic [SLOT_IDX_W-1:0] slot_wide;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign mem_re    = (state_reg == ST_SCAN) && (cnt_reg < CW'(NUM_SLOTS));

    lscp_ram #(
        .WIDTH ($bits(ent_t)),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    lscp_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .now_ticks (req.now_ticks),
        .sound_key (item_reg.sound_key),
        .rd_valid  (rd_pend_reg && (state_reg == ST_SCAN)),
        .rd_idx    (SLOT_IDX_W'(rd_idx_reg)),
        .rd_ent    (ent_t'(mem_rdata)),
        .trk       (trk)
    );

    always_comb
    begin
        victim_idx = trk.have_oldest ? trk.oldest_idx[IW-1:0] : '0;
        victim_key = trk.have_oldest ? trk.oldest_key : trk.key0;
        wr_want    = 1'b0;
        wr_idx     = '0;
        wr_ent     = '0;
        rsp_calc   = '0;
        if (item_en_reg)
        begin
            if (item_reg.req_type == REQ_FREE)
            begin
                if (trk.have_match)
                begin
                    wr_want               = 1'b1;
                    wr_idx                = trk.match_idx[IW-1:0];
                    rsp_calc.hit          = 1'b1;
                    rsp_calc.action_taken = 1'b1;
                end
            end
            else
            begin
                wr_want      = 1'b1;
                wr_ent.active = 1'b1;
                wr_ent.key   = item_reg.sound_key;
                wr_ent.stamp = item_reg.now_ticks;
                rsp_calc.action_taken = 1'b1;
                if (trk.have_match)
                begin
                    wr_idx       = trk.match_idx[IW-1:0];
                    rsp_calc.hit = 1'b1;
                end
                else if (trk.have_free)
                begin
                    wr_idx = trk.free_idx[IW-1:0];
                end
                else
                begin
                    wr_idx               = victim_idx;
                    rsp_calc.evicted     = 1'b1;
                    rsp_calc.evicted_key = victim_key;
                end
            end
        end
        slot_wide           = SLOT_IDX_W'(wr_idx);
        rsp_calc.slot_index = wr_want ? slot_wide[7:0] : 8'd0;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_idx;
        mem_wdata = wr_ent;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg[IW-1:0];
            mem_wdata = '0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            mem_we = wr_want;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        item_next      = item_reg;
        item_en_next   = item_en_reg;
        enable_next    = cfg_wr_en ? cfg_wr_data : enable_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUM_SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next    = req;
                    item_en_next = enable_reg;
                    cnt_next     = '0;
                    state_next   = enable_reg ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = mem_re;
                rd_idx_next  = cnt_reg[IW-1:0];
                if (mem_re)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (rd_pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_next       = rsp_calc;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            item_en_reg   <= 1'b0;
            enable_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            item_en_reg   <= item_en_next;
            enable_reg    <= enable_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        item_reg   <= item_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_no_action_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.action_taken) |->
            (rsp.slot_index == 8'd0) && !rsp.hit && !rsp.evicted && (rsp.evicted_key == 32'd0))
        else $error("no-action beat carries nonzero fields");

    a_evict_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.evicted) |-> (!rsp.hit && rsp.action_taken))
        else $error("eviction reported together with hit or without action");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !mem_we)
        else $error("entry memory written during scan");

    a_load_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_free) |=> (rsp_valid && (state_reg == ST_IDLE)))
        else $error("finished request did not load the output register");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lru_slot_cache_policy. A directed table covers the
// disabled block, free misses and hits, use hits, filling the free slots,
// eviction of the strictly oldest entry, ties, the no-older-time fallback to
// slot 0 and signed time compare. Random phases follow: keys from a pool
// close in size to the cache, mostly rising time with jumps and extremes,
// and enable switched between phases. Each accepted request is run through
// a local slot cache model and every result beat is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
    import lscp_pkg::*;

    localparam int SLOTS          = NUM_SLOTS_DEF;
    localparam int KEY_POOL       = 320;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int CYCLE_LIMIT    = 6_000_000;
    localparam int NUM_ROWS       = 25;
    localparam int NUM_PHASES     = 4;

    localparam logic        PHASE_EN    [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1};
    localparam int          PHASE_ITEMS [NUM_PHASES] = '{550, 450, 50, 400};
    localparam logic [31:0] PHASE_TICK  [NUM_PHASES] =
        '{32'h0000_0000, 32'h7FFF_D000, 32'h0000_0000, 32'hF000_0000};

    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

    localparam rsp_t NO_ACTION  = '0;
    localparam rsp_t SLOT0_FILL = '{8'd0, 1'b0, 1'b0, 32'h0, 1'b1};

    typedef enum logic [1:0] {
        ROW_REQ,
        ROW_CFG,
        ROW_FILL
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               en;
        logic               op;
        logic [31:0]        key;
        logic signed [31:0] now;
        logic               typed;
        rsp_t               want;
    } plan_row_t;

    plan_row_t plan [NUM_ROWS] = '{
        '{ROW_REQ,  1'b0, REQ_USE,  32'h1234_5678, 32'sd100,  1'b1, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_FREE, 32'h0000_0000, 32'sd0,    1'b1, NO_ACTION},
        '{ROW_CFG,  1'b1, REQ_USE,  32'h0000_0000, 32'sd0,    1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_FREE, 32'h0000_0000, 32'sd5,    1'b1, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_FREE, 32'hDEAD_BEEF, 32'sd6,    1'b1, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'h0000_0000, T_MIN,     1'b1, SLOT0_FILL},
        '{ROW_REQ,  1'b0, REQ_USE,  32'hFFFF_FFFF, T_MAX,     1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'h0000_0000, 32'sd7,    1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_FREE, 32'hFFFF_FFFF, 32'sd0,    1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_FREE, 32'hFFFF_FFFF, 32'sd0,    1'b1, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'hA5A5_A5A5, -32'sd1,   1'b0, NO_ACTION},
        '{ROW_CFG,  1'b0, REQ_USE,  32'h0000_0000, 32'sd0,    1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'h0000_0000, 32'sd9,    1'b1, NO_ACTION},
        '{ROW_CFG,  1'b1, REQ_USE,  32'h0000_0000, 32'sd0,    1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'h0000_0000, 32'sd9,    1'b0, NO_ACTION},
        '{ROW_FILL, 1'b0, REQ_USE,  32'h1000_0000, 32'sd1000, 1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'h5555_AAAA, 32'sd2000, 1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'h0BAD_F00D, 32'sd2000, 1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'h7777_7777, 32'sd3000, 1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'h8888_8888, 32'sd500,  1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'h9999_9999, T_MIN,     1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'hCAFE_F00D, 32'sd1500, 1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_FREE, 32'h1000_0005, 32'sd0,    1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'hFFFF_FFFF, 32'sd0,    1'b0, NO_ACTION},
        '{ROW_REQ,  1'b0, REQ_USE,  32'h1234_5678, T_MAX,     1'b0, NO_ACTION}
    };

    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic req_valid   = 1'b0;
    logic req_ready;
    req_t req         = '0;
    logic rsp_valid;
    logic rsp_ready   = 1'b0;
    rsp_t rsp;
    logic cfg_wr_en   = 1'b0;
    logic cfg_wr_data = 1'b0;

    logic               slot_on    [SLOTS];
    logic [31:0]        slot_key   [SLOTS];
    logic signed [31:0] slot_stamp [SLOTS];
    logic               audio_on;

    rsp_t               pending_rsp_q [$];
    logic [31:0]        key_pool [KEY_POOL];
    logic signed [31:0] tick;

    int burst_left    = 0;
    int holdoff_asked = 0;
    int holdoff_seen  = 0;
    int holdoff_left  = 0;
    logic [31:0] stall_bits = '1;
    logic [4:0]  stall_pos  = '0;

    int errors     = 0;
    int checked    = 0;
    int sent       = 0;
    int hits       = 0;
    int evictions  = 0;
    int frees_done = 0;
    int cycles     = 0;

    lru_slot_cache_policy i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still due", cycles,
                     pending_rsp_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic rsp_t cache_lookup(input req_t b);
        rsp_t               o;
        int                 i;
        int                 hit_at;
        int                 free_at;
        int                 old_at;
        int                 victim;
        logic signed [31:0] old_t;
        o       = '0;
        hit_at  = -1;
        free_at = -1;
        old_at  = -1;
        old_t   = b.now_ticks;
        if (!audio_on)
            return o;
        for (i = 0; i < SLOTS; i++)
        begin
            if (hit_at < 0 && slot_on[i] && slot_key[i] == b.sound_key)
                hit_at = i;
            if (free_at < 0 && !slot_on[i])
                free_at = i;
            if (slot_stamp[i] < old_t)
            begin
                old_t  = slot_stamp[i];
                old_at = i;
            end
        end
        if (b.req_type == REQ_FREE)
        begin
            if (hit_at >= 0)
            begin
                slot_on[hit_at]    = 1'b0;
                slot_key[hit_at]   = '0;
                slot_stamp[hit_at] = '0;
                o.slot_index       = 8'(hit_at);
                o.hit              = 1'b1;
                o.action_taken     = 1'b1;
            end
            return o;
        end
        o.action_taken = 1'b1;
        if (hit_at >= 0)
        begin
            slot_stamp[hit_at] = b.now_ticks;
            o.slot_index       = 8'(hit_at);
            o.hit              = 1'b1;
            return o;
        end
        if (free_at >= 0)
            victim = free_at;
        else
        begin
            victim        = (old_at >= 0) ? old_at : 0;
            o.evicted     = 1'b1;
            o.evicted_key = slot_key[victim];
        end
        slot_on[victim]    = 1'b1;
        slot_key[victim]   = b.sound_key;
        slot_stamp[victim] = b.now_ticks;
        o.slot_index       = 8'(victim);
        return o;
    endfunction

    function automatic int free_slot_count();
        int i;
        int n;
        n = 0;
        for (i = 0; i < SLOTS; i++)
            if (!slot_on[i])
                n++;
        return n;
    endfunction

    function automatic req_t random_beat();
        req_t b;
        b.req_type  = ($urandom_range(0, 99) < 15) ? REQ_FREE : REQ_USE;
        b.sound_key = ($urandom_range(0, 9) != 0) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                                  : $urandom;
        case ($urandom_range(0, 19))
            0: b.now_ticks = $urandom;
            1: b.now_ticks = T_MIN;
            2: b.now_ticks = T_MAX;
            3: b.now_ticks = tick - $urandom_range(0, 5000);
            default:
            begin
                tick        = tick + $urandom_range(0, 40);
                b.now_ticks = tick;
            end
        endcase
        return b;
    endfunction

    task automatic send_beat(input req_t b, input logic typed, input rsp_t want);
        int   gap;
        rsp_t p;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 12);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= b;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        p = cache_lookup(b);
        sent++;
        if (p.hit && b.req_type == REQ_USE)
            hits++;
        if (p.evicted)
            evictions++;
        if (p.action_taken && b.req_type == REQ_FREE)
            frees_done++;
        pending_rsp_q.push_back(typed ? want : p);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_enable(input logic v);
        drain();
        repeat (4) @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        audio_on = v;
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        if (pending_rsp_q.size() == 0)
        begin
            $error("result beat with nothing expected: slot_index %0d", got.slot_index);
            errors++;
            return;
        end
        want = pending_rsp_q.pop_front();
        checked++;
        if (got.slot_index !== want.slot_index)
        begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
            errors++;
        end
        if (got.hit !== want.hit)
        begin
            $error("hit: expected %0b, got %0b", want.hit, got.hit);
            errors++;
        end
        if (got.evicted !== want.evicted)
        begin
            $error("evicted: expected %0b, got %0b", want.evicted, got.evicted);
            errors++;
        end
        if (got.evicted_key !== want.evicted_key)
        begin
            $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
            errors++;
        end
        if (got.action_taken !== want.action_taken)
        begin
            $error("action_taken: expected %0b, got %0b", want.action_taken, got.action_taken);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            check_result(rsp);
        if (holdoff_seen != holdoff_asked)
        begin
            holdoff_seen <= holdoff_asked;
            holdoff_left <= HOLDOFF_CYCLES;
            rsp_ready    <= 1'b0;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            rsp_ready    <= 1'b0;
        end
        else
        begin
            rsp_ready <= stall_bits[stall_pos];
            stall_pos <= stall_pos + 5'd1;
            if (stall_pos == 5'd31)
                case ($urandom_range(0, 3))
                    0: stall_bits <= '1;
                    1: stall_bits <= $urandom;
                    2: stall_bits <= $urandom | $urandom;
                    default: stall_bits <= $urandom & $urandom;
                endcase
        end
    end

    initial
    begin : stimulus
        int   r;
        int   n;
        int   p;
        int   directed_sent;
        req_t b;
        for (n = 0; n < SLOTS; n++)
        begin
            slot_on[n]    = 1'b0;
            slot_key[n]   = '0;
            slot_stamp[n] = '0;
        end
        audio_on = 1'b0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (n = 2; n < KEY_POOL; n++)
            key_pool[n] = $urandom;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < NUM_ROWS; r++)
        begin
            case (plan[r].kind)
                ROW_CFG:
                    write_enable(plan[r].en);
                ROW_FILL:
                    for (n = 0; free_slot_count() != 0; n++)
                    begin
                        b = '{REQ_USE, plan[r].key + 32'(n), plan[r].now};
                        send_beat(b, 1'b0, NO_ACTION);
                    end
                default:
                begin
                    b = '{plan[r].op, plan[r].key, plan[r].now};
                    send_beat(b, plan[r].typed, plan[r].want);
                end
            endcase
        end
        directed_sent = sent;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_enable(PHASE_EN[p]);
            tick = PHASE_TICK[p];
            if (p == 1)
                holdoff_asked <= holdoff_asked + 1;
            for (n = 0; n < PHASE_ITEMS[p]; n++)
                send_beat(random_beat(), 1'b0, NO_ACTION);
        end

        drain();
        repeat (SLOTS + 16) @(posedge clk);

        $display("Sent %0d requests (%0d from the directed table), checked %0d results.",
                 sent, directed_sent, checked);
        $display("Model saw %0d use hits, %0d evictions, %0d frees that found their entry.",
                 hits, evictions, frees_done);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
